// ----- rtl/torus_distance_estimate_core_assert.svh -----
// Assertion macros used by the checker file.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef TORUS_DISTANCE_ESTIMATE_CORE_ASSERT_SVH
`define TORUS_DISTANCE_ESTIMATE_CORE_ASSERT_SVH

// Checked only while out of reset.
`define TDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define TDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tde_pkg.sv -----
// Types, constants and step functions of the torus distance estimate core.
// No dependencies; used by torus_distance_estimate_core.
package tde_pkg;

  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 33;

  localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    REG_CONTROL   = 4'd0,
    REG_MAJOR     = 4'd1,
    REG_MINOR     = 4'd2,
    REG_SHELL     = 4'd3,
    REG_SCALE_OFS = 4'd4,
    REG_COL_BASE  = 4'd5,
    REG_COL_ITER  = 4'd6,
    REG_COL_SHELL = 4'd7
  } reg_idx_t;

  localparam int unsigned CW_SWAP_XZ  = 0;
  localparam int unsigned CW_SWAP_YZ  = 1;
  localparam int unsigned CW_SHELL    = 2;
  localparam int unsigned CW_BOXNORM  = 3;
  localparam int unsigned CW_CUT_X    = 4;
  localparam int unsigned CW_CUT_Y    = 5;
  localparam int unsigned CW_COL_EN   = 6;
  localparam int unsigned CW_COL_ADD  = 7;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] dmin;
    logic signed [31:0] de;
    logic signed [31:0] col;
    logic [7:0]         iter;
    logic signed [31:0] cadd;
    logic               win;
    logic signed [31:0] base;
    logic signed [31:0] cheb;
    logic signed [31:0] tor;
    logic signed [31:0] den;
    logic               cond;
    logic               zero;
    logic               neg;
    logic               ovf;
    logic               tnn;
  } side_t;

  typedef struct packed {
    logic [63:0] n;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_state_t;

  typedef struct packed {
    logic [63:0] num;
    logic [33:0] rem;
    logic [31:0] den;
    logic [32:0] quo;
  } div_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(SMAX)) return SMAX;
    if (v < 66'(SMIN)) return SMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    return sat32(-66'(a));
  endfunction

  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] a);
    return (a < 0) ? neg_sat(a) : a;
  endfunction

  // Magnitude as unsigned; the smallest value maps to 2^31.
  function automatic logic [31:0] umag(input logic signed [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  // One result bit of the integer square root.
  function automatic sq_state_t sqrt_step(input sq_state_t s);
    sq_state_t   r;
    logic [35:0] rem2;
    logic [35:0] t;
    rem2  = {s.rem[33:0], s.n[63:62]};
    t     = {2'b00, s.root, 2'b01};
    r.n   = {s.n[61:0], 2'b00};
    if (rem2 >= t) begin
      r.rem  = rem2 - t;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of restoring division on magnitudes.
  function automatic div_state_t div_step(input div_state_t s);
    div_state_t  r;
    logic [33:0] r2;
    logic [33:0] dd;
    r2    = {s.rem[32:0], s.num[63]};
    dd    = {2'b00, s.den};
    r.num = {s.num[62:0], 1'b0};
    r.den = s.den;
    if (r2 >= dd) begin
      r.rem = r2 - dd;
      r.quo = {s.quo[31:0], 1'b1};
    end else begin
      r.rem = r2;
      r.quo = {s.quo[31:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/torus_distance_estimate_core.sv -----
// Torus distance estimate core: pipelined square roots and divider.
// Depends on tde_pkg.
//
// Usage:
//   Item channel: pos_x, pos_y, pos_z, dist_in, deriv_scale, iteration,
//   colour_in with item_valid / item_stall. Result channel: dist_out,
//   colour_out, improved with result_valid / result_stall. A transfer
//   happens on a rising edge with valid high and stall low.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write registers only while the core is idle.
//   Throughput: one item per cycle while no stalled result holds the
//   pipeline. The path holds two 32-step square root pipelines
//   and a 33-step divider pipeline, one bit per stage.
//   Reset (rst, synchronous) empties the pipeline and loads register
//   defaults. When the receiver stalls a waiting result, the whole
//   pipeline holds; the input register still takes one more item.
module torus_distance_estimate_core
  import tde_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] dist_in,
  input  logic signed [31:0] deriv_scale,
  input  logic [7:0]         iteration,
  input  logic signed [31:0] colour_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] dist_out,
  output logic signed [31:0] colour_out,
  output logic               improved
);

  localparam logic signed [31:0] MAJOR_RST = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] MINOR_RST = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [31:0] SHELL_RST =
    32'((64'd5 * (64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

  logic [23:0]        control_word;
  logic signed [31:0] major_radius, minor_radius, shell_thickness, scale_offset;
  logic signed [31:0] colour_base, colour_per_iteration, colour_shell_extra;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_word         <= '0;
      major_radius         <= MAJOR_RST;
      minor_radius         <= MINOR_RST;
      shell_thickness      <= SHELL_RST;
      scale_offset         <= '0;
      colour_base          <= '0;
      colour_per_iteration <= '0;
      colour_shell_extra   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CONTROL:   control_word         <= cfg_data[23:0];
        REG_MAJOR:     major_radius         <= cfg_data;
        REG_MINOR:     minor_radius         <= cfg_data;
        REG_SHELL:     shell_thickness      <= cfg_data;
        REG_SCALE_OFS: scale_offset         <= cfg_data;
        REG_COL_BASE:  colour_base          <= cfg_data;
        REG_COL_ITER:  colour_per_iteration <= cfg_data;
        REG_COL_SHELL: colour_shell_extra   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic shell;
  assign shell = control_word[CW_SHELL];

  // Global advance: everything moves unless a finished result is held.
  logic adv;
  assign adv = !(result_valid && result_stall);

  // Input register
  logic  in_v;
  side_t in_q;
  side_t in_next;
  assign item_stall = in_v && !adv;

  always_comb begin
    in_next      = '0;
    in_next.x    = pos_x;
    in_next.y    = pos_y;
    in_next.z    = pos_z;
    in_next.dmin = dist_in;
    in_next.de   = deriv_scale;
    in_next.iter = iteration;
    in_next.col  = colour_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (adv || !in_v) begin
      in_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= in_next;
    end
  end

  // Stage 1: axis swaps, squares, colour product
  side_t              sw;
  logic               v1;
  side_t              sd1;
  logic [63:0]        sqx1, sqy1;
  logic signed [40:0] prod1;

  always_comb begin
    sw = in_q;
    if (control_word[CW_SWAP_XZ]) begin
      sw.x = in_q.z;
      sw.z = in_q.x;
    end
    if (control_word[CW_SWAP_YZ]) begin
      sw.y = sw.z;
      sw.z = in_q.y;
    end
    sw.win = (in_q.iter >= control_word[15:8]) && (in_q.iter < control_word[23:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1   <= sw;
      sqx1  <= 64'(umag(sw.x)) * 64'(umag(sw.x));
      sqy1  <= 64'(umag(sw.y)) * 64'(umag(sw.y));
      prod1 <= $signed({1'b0, in_q.iter}) * colour_per_iteration;
    end
  end

  // Stage 2: sum of squares, base colour term
  logic        v2;
  side_t       sd2;
  side_t       sd2_next;
  logic [63:0] n2;

  always_comb begin
    sd2_next      = sd1;
    sd2_next.cadd = add_sat(colour_base, sat32(66'(prod1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd2 <= sd2_next;
      n2  <= sqx1 + sqy1;
    end
  end

  // Square root of the ring radius
  sq_state_t sq1_st [SQ_STEPS];
  side_t     sq1_sd [SQ_STEPS];
  logic      sq1_v  [SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq1
    sq_state_t st_i;
    side_t     sd_i;
    logic      v_i;
    if (g == 0) begin : g_head
      assign st_i = '{n: n2, rem: '0, root: '0};
      assign sd_i = sd2;
      assign v_i  = v2;
    end else begin : g_body
      assign st_i = sq1_st[g-1];
      assign sd_i = sq1_sd[g-1];
      assign v_i  = sq1_v[g-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq1_v[g] <= 1'b0;
      end else if (adv) begin
        sq1_v[g] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_st[g] <= sqrt_step(st_i);
        sq1_sd[g] <= sd_i;
      end
    end
  end

  // Ring distance and base offset
  logic               vr;
  side_t              sdr;
  side_t              sdr_next;
  logic signed [31:0] ring_r;

  always_comb begin
    sdr_next      = sq1_sd[SQ_STEPS-1];
    sdr_next.base = shell ? sub_sat(shell_thickness, minor_radius) : neg_sat(minor_radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= sq1_v[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdr    <= sdr_next;
      ring_r <= sat32(66'($signed({34'd0, sq1_st[SQ_STEPS-1].root})) - 66'(major_radius));
    end
  end

  // Squares of ring and z, Chebyshev distance
  logic               vq;
  side_t              sdq;
  side_t              sdq_next;
  logic [63:0]        sqr_q, sqz_q;
  logic signed [31:0] ra, zb;

  assign ra = abs_sat(ring_r);
  assign zb = abs_sat(sdr.z);

  always_comb begin
    sdq_next      = sdr;
    sdq_next.cheb = add_sat((ra > zb) ? ra : zb, sdr.base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (adv) begin
      vq <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdq   <= sdq_next;
      sqr_q <= 64'(umag(ring_r)) * 64'(umag(ring_r));
      sqz_q <= 64'(umag(sdr.z)) * 64'(umag(sdr.z));
    end
  end

  logic        vs;
  side_t       sds;
  logic [63:0] ns;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sds <= sdq;
      ns  <= sqr_q + sqz_q;
    end
  end

  // Square root of the tube distance
  sq_state_t sq2_st [SQ_STEPS];
  side_t     sq2_sd [SQ_STEPS];
  logic      sq2_v  [SQ_STEPS];

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq2
    sq_state_t st_i;
    side_t     sd_i;
    logic      v_i;
    if (g == 0) begin : g_head
      assign st_i = '{n: ns, rem: '0, root: '0};
      assign sd_i = sds;
      assign v_i  = vs;
    end else begin : g_body
      assign st_i = sq2_st[g-1];
      assign sd_i = sq2_sd[g-1];
      assign v_i  = sq2_v[g-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq2_v[g] <= 1'b0;
      end else if (adv) begin
        sq2_v[g] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_st[g] <= sqrt_step(st_i);
        sq2_sd[g] <= sd_i;
      end
    end
  end

  // Torus distance
  logic               vt1;
  side_t              sdt1;
  logic signed [31:0] saved_t1;
  logic [31:0]        root2;
  logic signed [31:0] r2s;

  assign root2 = sq2_st[SQ_STEPS-1].root;
  assign r2s   = root2[31] ? SMAX : $signed(root2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vt1 <= 1'b0;
    end else if (adv) begin
      vt1 <= sq2_v[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdt1     <= sq2_sd[SQ_STEPS-1];
      saved_t1 <= control_word[CW_BOXNORM] ? sq2_sd[SQ_STEPS-1].cheb
                                           : add_sat(r2s, sq2_sd[SQ_STEPS-1].base);
    end
  end

  // Shell, cut planes, divisor
  logic               vt2;
  side_t              sdt2;
  side_t              sdt2_next;
  logic signed [31:0] ts, tc, cx, cy;

  always_comb begin
    ts = sub_sat(abs_sat(saved_t1), shell_thickness);
    if (ts < 0) begin
      ts = '0;
    end
    tc = shell ? ts : saved_t1;
    cx = neg_sat(sdt1.x);
    cy = neg_sat(sdt1.y);
    if (control_word[CW_CUT_X] && (cx > tc)) begin
      tc = cx;
    end
    if (control_word[CW_CUT_Y] && (cy > tc)) begin
      tc = cy;
    end
  end

  always_comb begin
    sdt2_next      = sdt1;
    sdt2_next.tor  = tc;
    sdt2_next.den  = add_sat(sdt1.de, scale_offset);
    sdt2_next.cond = shell && (ts >= add_sat(saved_t1, shell_thickness));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt2 <= 1'b0;
    end else if (adv) begin
      vt2 <= vt1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdt2 <= sdt2_next;
    end
  end

  // Divider setup
  logic        vd0;
  side_t       sdd0;
  side_t       sdd0_next;
  div_state_t  std0;
  logic [63:0] nmag;
  logic [31:0] dmag;

  assign nmag = 64'(umag(sdt2.tor)) << FRAC_BITS;
  assign dmag = umag(sdt2.den);

  always_comb begin
    sdd0_next      = sdt2;
    sdd0_next.cadd = sdt2.cond ? add_sat(sdt2.cadd, colour_shell_extra) : sdt2.cadd;
    sdd0_next.zero = (sdt2.den == 0);
    sdd0_next.neg  = sdt2.tor[31] ^ sdt2.den[31];
    sdd0_next.tnn  = !sdt2.tor[31];
    sdd0_next.ovf  = (nmag >> 33) >= 64'(dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd0 <= 1'b0;
    end else if (adv) begin
      vd0 <= vt2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sdd0 <= sdd0_next;
      std0 <= '{num: nmag << 31, rem: 34'(nmag >> 33), den: dmag, quo: '0};
    end
  end

  div_state_t dv_st [DIV_STEPS];
  side_t      dv_sd [DIV_STEPS];
  logic       dv_v  [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    div_state_t st_i;
    side_t      sd_i;
    logic       v_i;
    if (g == 0) begin : g_head
      assign st_i = std0;
      assign sd_i = sdd0;
      assign v_i  = vd0;
    end else begin : g_body
      assign st_i = dv_st[g-1];
      assign sd_i = dv_sd[g-1];
      assign v_i  = dv_v[g-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g] <= 1'b0;
      end else if (adv) begin
        dv_v[g] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_st[g] <= div_step(st_i);
        dv_sd[g] <= sd_i;
      end
    end
  end

  // Output stage: saturate quotient, update minimum and colour
  side_t              fs;
  logic [32:0]        quo;
  logic signed [31:0] q, col_next;
  logic               imp;

  assign fs  = dv_sd[DIV_STEPS-1];
  assign quo = dv_st[DIV_STEPS-1].quo;

  always_comb begin
    if (fs.zero) begin
      q = fs.tnn ? SMAX : SMIN;
    end else if (fs.neg) begin
      q = (fs.ovf || (quo > 33'h0_8000_0000)) ? SMIN : (~quo[31:0] + 32'd1);
    end else begin
      q = (fs.ovf || (quo >= 33'h0_8000_0000)) ? SMAX : quo[31:0];
    end
    imp      = q < fs.dmin;
    col_next = fs.col;
    if (control_word[CW_COL_EN] && imp && fs.win) begin
      col_next = control_word[CW_COL_ADD] ? add_sat(fs.col, fs.cadd) : fs.cadd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= dv_v[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_out   <= imp ? q : fs.dmin;
      colour_out <= col_next;
      improved   <= imp;
    end
  end

endmodule

// ----- rtl/tde_checker.sv -----
// Port-level checker for torus_distance_estimate_core, bound to every core instance.
// Depends on torus_distance_estimate_core_assert.svh.
`include "torus_distance_estimate_core_assert.svh"

module tde_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] dist_out,
  input logic signed [31:0] colour_out,
  input logic               improved
);

  `TDE_ASSERT_ALWAYS(a_rst_empty, rst |=> !result_valid, "result after reset")
  `TDE_ASSERT(a_stall_backpressure, item_stall |-> (result_valid && result_stall),
    "input stalled without held result")
  `TDE_ASSERT(a_result_held, (result_valid && result_stall) |=> result_valid,
    "stalled result dropped")
  `TDE_ASSERT(a_result_stable,
    (result_valid && result_stall) |=> ($stable(dist_out) && $stable(colour_out)
      && $stable(improved)), "stalled result changed")

endmodule

bind torus_distance_estimate_core tde_checker u_tde_checker (.*);

// ----- bench/tb.sv -----
// Self-checking testbench for torus_distance_estimate_core.
// Depends on tde_pkg and the core; drives points and register writes and
// compares every result with an internal torus distance predictor.
`timescale 1ns / 100ps

module tb;
  import tde_pkg::*;

  typedef struct {
    logic signed [31:0] x, y, z, dmin, de, col;
    logic [7:0]         iter;
  } point_t;

  typedef struct {
    logic signed [31:0] dmin, col;
    logic               imp;
  } estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] dist_in = '0, deriv_scale = '0, colour_in = '0;
  logic [7:0] iteration = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] dist_out, colour_out;
  logic improved;

  // local copy of the register file
  logic [23:0]        m_ctrl;
  logic signed [31:0] m_major, m_minor, m_shell, m_sofs, m_cbase, m_citer, m_cshell;

  estimate_t est_q[$];
  int  err_cnt = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  int  hold_cnt = 0;
  int  stall_left = 0;

  torus_distance_estimate_core i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic signed [31:0] sat(input longint v);
    if (v > longint'(SMAX)) return SMAX;
    if (v < longint'(SMIN)) return SMIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sqr(input logic signed [31:0] v);
    longint unsigned a;
    a = (v < 0) ? longint'(-longint'(v)) : longint'(v);
    return a * a;
  endfunction

  function automatic logic signed [31:0] mag(input logic signed [31:0] v);
    return sat((v < 0) ? -longint'(v) : longint'(v));
  endfunction

  function automatic estimate_t predict_torus(input point_t p);
    estimate_t r;
    logic signed [31:0] x, y, z, t, ring, base, tor, saved, den, q, a, b, c, add;
    logic shell;
    x = p.x; y = p.y; z = p.z;
    shell = m_ctrl[CW_SHELL];
    if (m_ctrl[CW_SWAP_XZ]) begin t = x; x = z; z = t; end
    if (m_ctrl[CW_SWAP_YZ]) begin t = y; y = z; z = t; end
    ring = sat(longint'(root64(sqr(x) + sqr(y))) - longint'(m_major));
    base = shell ? sat(longint'(m_shell) - longint'(m_minor)) : sat(-longint'(m_minor));
    if (m_ctrl[CW_BOXNORM]) begin
      a = mag(ring);
      b = mag(z);
      tor = sat(longint'((a > b) ? a : b) + longint'(base));
    end else begin
      t = sat(longint'(root64(sqr(ring) + sqr(z))));
      tor = sat(longint'(t) + longint'(base));
    end
    saved = tor;
    if (shell) begin
      tor = sat(longint'(mag(tor)) - longint'(m_shell));
      if (tor < 0) tor = 0;
      ring = tor;
    end
    if (m_ctrl[CW_CUT_X]) begin
      c = sat(-longint'(x));
      if (c > tor) tor = c;
    end
    if (m_ctrl[CW_CUT_Y]) begin
      c = sat(-longint'(y));
      if (c > tor) tor = c;
    end
    den = sat(longint'(p.de) + longint'(m_sofs));
    if (den == 0) q = (tor >= 0) ? SMAX : SMIN;
    else q = sat((longint'(tor) * 65536) / longint'(den));
    r.imp = q < p.dmin;
    r.dmin = r.imp ? q : p.dmin;
    r.col = p.col;
    if (m_ctrl[CW_COL_EN] && r.imp && p.iter >= m_ctrl[15:8] && p.iter < m_ctrl[23:16]) begin
      add = sat(longint'(m_cbase) + longint'(sat(longint'(p.iter) * longint'(m_citer))));
      if (shell && ring >= sat(longint'(saved) + longint'(m_shell)))
        add = sat(longint'(add) + longint'(m_cshell));
      r.col = m_ctrl[CW_COL_ADD] ? sat(longint'(p.col) + longint'(add)) : add;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_fix();
    case ($urandom_range(0, 9))
      0: return SMIN;
      1: return SMAX;
      2: return 0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 524288)) - 262144;
    endcase
  endfunction

  function automatic point_t rnd_point();
    point_t p;
    p.x = rnd_fix(); p.y = rnd_fix(); p.z = rnd_fix();
    p.dmin = rnd_fix(); p.col = rnd_fix();
    case ($urandom_range(0, 7))
      0: p.de = 0;
      1: p.de = $urandom;
      2: p.de = -$signed($urandom_range(1, 262144));
      default: p.de = $signed($urandom_range(65536, 262144));
    endcase
    p.iter = $urandom_range(0, 255);
    return p;
  endfunction

  function automatic point_t mk(input logic signed [31:0] x, y, z, dmin, de,
                                input logic [7:0] iter, input logic signed [31:0] col);
    point_t p;
    p.x = x; p.y = y; p.z = z; p.dmin = dmin; p.de = de; p.iter = iter; p.col = col;
    return p;
  endfunction

  task automatic send_item(input point_t p);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    pos_x <= p.x; pos_y <= p.y; pos_z <= p.z;
    dist_in <= p.dmin; deriv_scale <= p.de; iteration <= p.iter; colour_in <= p.col;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    est_q.push_back(predict_torus(p));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (est_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CONTROL:   m_ctrl = v[23:0];
      REG_MAJOR:     m_major = v;
      REG_MINOR:     m_minor = v;
      REG_SHELL:     m_shell = v;
      REG_SCALE_OFS: m_sofs = v;
      REG_COL_BASE:  m_cbase = v;
      REG_COL_ITER:  m_citer = v;
      REG_COL_SHELL: m_cshell = v;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] ctrl, input logic signed [31:0] v);
    write_reg(REG_CONTROL, {8'd0, ctrl});
    write_reg(REG_MAJOR, v);
    write_reg(REG_MINOR, v);
    write_reg(REG_SHELL, v);
    write_reg(REG_SCALE_OFS, v);
    write_reg(REG_COL_BASE, v);
    write_reg(REG_COL_ITER, v);
    write_reg(REG_COL_SHELL, v);
  endtask

  task automatic random_config();
    write_reg(REG_CONTROL, {8'd0, 8'($urandom_range(0, 40)), 8'($urandom_range(0, 12)),
                            8'($urandom)});
    write_reg(REG_MAJOR, $signed($urandom_range(0, 196608)));
    write_reg(REG_MINOR, $signed($urandom_range(0, 98304)));
    write_reg(REG_SHELL, $signed($urandom_range(0, 8192)));
    write_reg(REG_SCALE_OFS, ($urandom_range(0, 3) == 0) ? rnd_fix() : 0);
    write_reg(REG_COL_BASE, rnd_fix());
    write_reg(REG_COL_ITER, rnd_fix());
    write_reg(REG_COL_SHELL, rnd_fix());
  endtask

  task automatic test_reset_defaults();
    send_item(mk(0, 0, 0, SMAX, 32'sh10000, 0, 0));
    send_item(mk(32'sh10000, 0, 0, SMAX, 32'sh10000, 1, 5));
    send_item(mk(32'sh18000, 32'sh8000, 32'sh4000, 0, 32'sh20000, 2, 7));
    send_item(mk(-32'sh30000, 32'sh10000, 0, SMAX, 0, 3, 9));
  endtask

  task automatic test_extremes();
    write_all(24'hFFFFFF, SMIN);
    write_reg(REG_CONTROL, {8'd0, 8'hFF, 8'h00, 8'hFF});
    send_item(mk(SMIN, SMIN, SMIN, SMAX, SMIN, 8'hFF, SMIN));
    send_item(mk(SMAX, SMAX, SMAX, SMIN, SMAX, 8'h00, SMAX));
    write_all(24'h000000, SMAX);
    send_item(mk(SMIN, SMAX, SMIN, SMAX, 0, 8'hFF, SMAX));
    send_item(mk(SMAX, SMIN, SMAX, SMAX, 0, 8'h00, SMIN));
    write_all(24'hFFFFFF, SMAX);
    send_item(mk(SMIN, SMIN, SMIN, SMAX, SMIN, 8'hFE, SMAX));
    send_item(mk(0, 0, 0, SMAX, 0, 8'h80, SMIN));
  endtask

  task automatic test_modes();
    write_reg(REG_MAJOR, 32'sh10000);
    write_reg(REG_MINOR, 32'sh8000);
    write_reg(REG_SHELL, 32'sh148);
    write_reg(REG_SCALE_OFS, 0);
    write_reg(REG_COL_BASE, 32'sh1000);
    write_reg(REG_COL_ITER, 32'sh200);
    write_reg(REG_COL_SHELL, 32'sh50000);
    for (int b = 0; b < 8; b++) begin
      write_reg(REG_CONTROL, {8'd0, 8'd10, 8'd2, 8'(1 << b) | 8'h40});
      send_item(mk(-32'sh8000, -32'sh14000, 32'sh4000, SMAX, 32'sh10000, 5, 32'sh100));
    end
    // empty colour window: start equals stop
    write_reg(REG_CONTROL, {8'd0, 8'd4, 8'd4, 8'hC0});
    send_item(mk(0, 0, 0, SMAX, 32'sh10000, 4, 32'sh100));
  endtask

  task automatic test_random(input int n);
    random_config();
    repeat (n) send_item(rnd_point());
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    @(posedge clk);
    hold_cnt <= 400;
    repeat (150) send_item(rnd_point());
    drain();
    send_idle = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    estimate_t e;
    if (!rst && result_valid && !result_stall) begin
      if (est_q.size() == 0) begin
        $error("result with no expectation waiting");
        err_cnt++;
      end else begin
        e = est_q.pop_front();
        if (dist_out !== e.dmin) begin
          $error("dist_out expected %0d actual %0d", e.dmin, dist_out);
          err_cnt++;
        end
        if (colour_out !== e.col) begin
          $error("colour_out expected %0d actual %0d", e.col, colour_out);
          err_cnt++;
        end
        if (improved !== e.imp) begin
          $error("improved expected %0d actual %0d", e.imp, improved);
          err_cnt++;
        end
      end
    end
    if (hold_cnt > 0) begin
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    m_ctrl = '0; m_major = 32'sh10000; m_minor = 32'sh8000; m_shell = 32'sd328;
    m_sofs = 0; m_cbase = 0; m_citer = 0; m_cshell = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_modes();
    for (int i = 0; i < 6; i++) test_random(55);
    test_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(50);
    drain();
    repeat (120) @(posedge clk);
    if (err_cnt == 0 && est_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
